@@ sv/sclc_pkg.sv @@
// ----------------------------------------------------------------------------
// Stepper closed-loop commutation package
// Shared types and constants: widths, result actions, register indexes and step directions.
// ----------------------------------------------------------------------------
package sclc_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned StepW  = 16;
  localparam int unsigned CommW  = 20;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef enum logic [1:0] {
    ACT_TARGET   = 2'd0,
    ACT_PROGRESS = 2'd1,
    ACT_STEP     = 2'd2,
    ACT_RESYNC   = 2'd3
  } action_e;

  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_COMM      = 2'd1;
  localparam logic [1:0] REG_REF_POS   = 2'd2;
  localparam logic [1:0] REG_REF_CNT   = 2'd3;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

endpackage

@@ sv/stepper_closed_loop_commutation.sv @@
// ----------------------------------------------------------------------------
// Stepper closed-loop commutation
// Decides the commutation action for each encoder beat, using one shared
// radix-2 signed divider for pole rounding and step count correction.
// ----------------------------------------------------------------------------
// Passes through the shared divider: one on the first beat after reset, one
// for a step, two for a resync; a resync on the first beat takes three.
// A new beat is taken only in the idle state, after the previous one has been
// placed in the output register; that register lets the next beat enter while
// a result waits.
// Reset: control and configuration registers take their reset values, the pole
// is marked unknown and the output register is empty.
module stepper_closed_loop_commutation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            encoder_position_i,
  input  logic signed [31:0]            set_point_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sclc_pkg::action_e             action_o,
  output logic signed [1:0]             step_dir_o,
  output logic signed [31:0]            pole_position_o,
  output logic                          resync_valid_o,
  output logic signed [31:0]            corrected_step_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sclc_pkg::AddrW-1:0]    paddr,
  input  logic [sclc_pkg::DataW-1:0]    pwdata,
  output logic [sclc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import sclc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_INIT, S_EVAL1, S_EVAL2, S_POLE, S_CORR, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_INIT, PH_POLE, PH_CORR
  } phase_e;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;

  logic [StepW-1:0]   step_q, step_d;
  logic [CommW-1:0]   comm_q, comm_d;
  logic [31:0]        ref_pos_q, ref_pos_d;
  logic [31:0]        ref_cnt_q, ref_cnt_d;

  logic [31:0]        pole_q, pole_d;
  logic               pole_known_q, pole_known_d;

  logic [31:0]        pos_q, pos_d;
  logic [31:0]        set_q, set_d;
  logic               dir_pos_q, dir_pos_d;
  action_e            act_q, act_d;
  logic [31:0]        corr_q, corr_d;

  logic [31:0]        mm_q, mm_d;
  logic [32:0]        adiff_q, adiff_d;
  logic [31:0]        lo_q, lo_d;
  logic [31:0]        hi_q, hi_d;

  logic [31:0]        dvd_q, dvd_d;
  logic [31:0]        x_q, x_d;
  logic [StepW-1:0]   rem_q, rem_d;
  logic               neg_q, neg_d;
  logic [4:0]         cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  action_e            out_act_q, out_act_d;
  logic [1:0]         out_dir_q, out_dir_d;
  logic [31:0]        out_pole_q, out_pole_d;
  logic               out_rv_q, out_rv_d;
  logic [31:0]        out_corr_q, out_corr_d;

  logic [StepW-1:0]   st_eff;
  logic [31:0]        st32;
  logic [31:0]        comm32;
  logic [31:0]        half32;
  logic [StepW:0]     rem_sh;
  logic               rem_ge;
  logic [31:0]        rem_s;
  logic [31:0]        quo_s;
  logic [31:0]        diff_w;
  logic [31:0]        mmx_w;
  logic [31:0]        cp_w;
  logic [31:0]        dvd_pole_w;
  logic [31:0]        dvd_corr_w;
  logic [31:0]        init_p_w;
  logic [31:0]        pole_new_w;
  logic [31:0]        steps_w;
  logic signed [33:0] min_w;
  logic signed [33:0] min_st_w;
  logic signed [33:0] mm34_w;
  logic signed [33:0] comm34_w;
  logic               c_target;
  logic               c_progress;
  logic               c_step;
  logic               cfg_we;
  logic               out_free;

  assign st_eff  = (step_q == '0) ? StepW'(1) : step_q;
  assign st32    = {16'b0, st_eff};
  assign comm32  = {12'b0, comm_q};
  assign half32  = {17'b0, st_eff[StepW-1:1]};

  assign rem_sh  = {rem_q, dvd_q[31]};
  assign rem_ge  = rem_sh >= {1'b0, st_eff};
  assign rem_s   = neg_q ? (32'd0 - {16'b0, rem_q}) : {16'b0, rem_q};
  assign quo_s   = neg_q ? (32'd0 - dvd_q) : dvd_q;

  assign diff_w  = set_q - pole_q;
  assign mmx_w   = pole_q - pos_q;
  assign cp_w    = pos_q - ref_pos_q;
  assign dvd_pole_w = dir_pos_q ? (pos_q + comm32 - st32) : (pos_q - comm32 + st32);
  assign dvd_corr_w = dir_pos_q ? (cp_w + comm32 - st32) : (cp_w - comm32 + st32);

  assign init_p_w = ($signed(rem_s) >= $signed(half32)) ? (pos_q - rem_s + st32)
                                                         : (pos_q - rem_s);
  assign pole_new_w = dir_pos_q ? (x_q - rem_s + st32)
                                : ((rem_q == '0) ? (x_q - st32) : (x_q - rem_s));
  assign steps_w = quo_s + {31'b0, (!dir_pos_q && (rem_q != '0))};

  assign comm34_w = $signed({14'b0, comm_q});
  assign min_w    = comm34_w - $signed({18'b0, st_eff});
  assign min_st_w = min_w - $signed({18'b0, st_eff});
  assign mm34_w   = $signed({{2{mm_q[31]}}, mm_q});

  assign c_target   = ($signed(lo_q) < $signed(pos_q)) && ($signed(hi_q) > $signed(pos_q))
                      && (adiff_q <= {1'b0, half32});
  assign c_progress = (min_w < mm34_w) && (comm34_w >= mm34_w);
  assign c_step     = (min_w >= mm34_w) && (min_st_w < mm34_w);

  assign cfg_we   = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign action_o    = out_act_q;
  assign step_dir_o  = out_dir_q;
  assign pole_position_o        = out_pole_q;
  assign resync_valid_o         = out_rv_q;
  assign corrected_step_count_o = out_corr_q;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_STEP_SIZE: prdata = {16'b0, step_q};
      REG_COMM:      prdata = {12'b0, comm_q};
      REG_REF_POS:   prdata = ref_pos_q;
      REG_REF_CNT:   prdata = ref_cnt_q;
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    step_d       = step_q;
    comm_d       = comm_q;
    ref_pos_d    = ref_pos_q;
    ref_cnt_d    = ref_cnt_q;
    pole_d       = pole_q;
    pole_known_d = pole_known_q;
    pos_d        = pos_q;
    set_d        = set_q;
    dir_pos_d    = dir_pos_q;
    act_d        = act_q;
    corr_d       = corr_q;
    mm_d         = mm_q;
    adiff_d      = adiff_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    dvd_d        = dvd_q;
    x_d          = x_q;
    rem_d        = rem_q;
    neg_d        = neg_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_act_d    = out_act_q;
    out_dir_d    = out_dir_q;
    out_pole_d   = out_pole_q;
    out_rv_d     = out_rv_q;
    out_corr_d   = out_corr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we) begin
      case (paddr[3:2])
        REG_STEP_SIZE: step_d    = pwdata[StepW-1:0];
        REG_COMM:      comm_d    = pwdata[CommW-1:0];
        REG_REF_POS:   ref_pos_d = pwdata;
        REG_REF_CNT:   ref_cnt_d = pwdata;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d     = encoder_position_i;
          set_d     = set_point_i;
          dir_pos_d = encoder_position_i <= set_point_i;
          if (pole_known_q) begin
            state_d = S_EVAL1;
          end else begin
            x_d     = encoder_position_i;
            neg_d   = encoder_position_i[31];
            dvd_d   = encoder_position_i[31] ? (32'd0 - encoder_position_i)
                                             : encoder_position_i;
            rem_d   = '0;
            cnt_d   = '0;
            phase_d = PH_INIT;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = rem_ge ? StepW'(rem_sh - {1'b0, st_eff}) : rem_sh[StepW-1:0];
        dvd_d = {dvd_q[30:0], rem_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          case (phase_q)
            PH_INIT: state_d = S_INIT;
            PH_POLE: state_d = S_POLE;
            PH_CORR: state_d = S_CORR;
            default: state_d = S_INIT;
          endcase
        end
      end
      S_INIT: begin
        pole_d       = init_p_w;
        pole_known_d = 1'b1;
        state_d      = S_EVAL1;
      end
      S_EVAL1: begin
        mm_d    = dir_pos_q ? mmx_w : (32'd0 - mmx_w);
        adiff_d = diff_w[31] ? (33'd0 - {1'b1, diff_w}) : {1'b0, diff_w};
        lo_d    = pole_q - st32;
        hi_d    = pole_q + st32;
        state_d = S_EVAL2;
      end
      S_EVAL2: begin
        corr_d = '0;
        if (c_target) begin
          act_d   = ACT_TARGET;
          state_d = S_DONE;
        end else if (c_progress) begin
          act_d   = ACT_PROGRESS;
          state_d = S_DONE;
        end else begin
          act_d   = c_step ? ACT_STEP : ACT_RESYNC;
          x_d     = dvd_pole_w;
          neg_d   = dvd_pole_w[31];
          dvd_d   = dvd_pole_w[31] ? (32'd0 - dvd_pole_w) : dvd_pole_w;
          rem_d   = '0;
          cnt_d   = '0;
          phase_d = PH_POLE;
          state_d = S_DIV;
        end
      end
      S_POLE: begin
        pole_d = pole_new_w;
        if (act_q == ACT_RESYNC) begin
          x_d     = dvd_corr_w;
          neg_d   = dvd_corr_w[31];
          dvd_d   = dvd_corr_w[31] ? (32'd0 - dvd_corr_w) : dvd_corr_w;
          rem_d   = '0;
          cnt_d   = '0;
          phase_d = PH_CORR;
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CORR: begin
        corr_d  = ref_cnt_q + steps_w;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_act_d   = act_q;
          out_pole_d  = pole_q;
          out_rv_d    = (act_q == ACT_RESYNC);
          if (act_q == ACT_STEP || act_q == ACT_RESYNC) begin
            out_dir_d = dir_pos_q ? DIR_POS : DIR_NEG;
          end else begin
            out_dir_d = DIR_NONE;
          end
          out_corr_d = corr_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_INIT;
      step_q       <= StepW'(1);
      comm_q       <= '0;
      ref_pos_q    <= '0;
      ref_cnt_q    <= '0;
      pole_q       <= '0;
      pole_known_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      step_q       <= step_d;
      comm_q       <= comm_d;
      ref_pos_q    <= ref_pos_d;
      ref_cnt_q    <= ref_cnt_d;
      pole_q       <= pole_d;
      pole_known_q <= pole_known_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    set_q      <= set_d;
    dir_pos_q  <= dir_pos_d;
    act_q      <= act_d;
    corr_q     <= corr_d;
    mm_q       <= mm_d;
    adiff_q    <= adiff_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    dvd_q      <= dvd_d;
    x_q        <= x_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_act_q  <= out_act_d;
    out_dir_q  <= out_dir_d;
    out_pole_q <= out_pole_d;
    out_rv_q   <= out_rv_d;
    out_corr_q <= out_corr_d;
  end

  a_rem_below_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < st_eff))
    else $error("Divider remainder reached the step size.");

  a_pole_known_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL1) |-> pole_known_q)
    else $error("Evaluation started without a known pole.");

  a_resync_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rv_q == (out_act_q == ACT_RESYNC)))
    else $error("Resync flag disagrees with the action.");

  a_dir_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_dir_q == DIR_NONE) ==
                     (out_act_q == ACT_TARGET || out_act_q == ACT_PROGRESS)))
    else $error("Step direction disagrees with the action.");

endmodule
